// ----- design/svs_pkg.sv -----
// ----------------------------------------------------------------------------
// svs_pkg
// Shared constants, widths, register codes and controller/datapath structs
// for the sliding window vote smoother.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int WINDOW_MAX  = 32;
  localparam int NUM_CLASSES = 8;

  // Fixed field widths.
  localparam int CLASS_W = 4;
  localparam int CONF_W  = 16;
  localparam int WIN_W   = 6;
  localparam int VOTE_W  = 6;

  // Derived widths.
  localparam int PTR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int SUM_W     = CONF_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

  localparam logic [CONF_W-1:0] THRESHOLD_RESET = CONF_W'(32768);
  localparam logic [WIN_W-1:0]  WINDOW_RESET    = WIN_W'(5);

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CONF_W-1:0]  conf;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             store;
    logic             rd;
    logic             acc;
    logic             scan;
    logic [CLS_W-1:0] scan_idx;
    logic             div_start;
    logic             out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] occ;
    logic             div_done;
    logic             out_free;
  } stat_t;

endpackage

// ----- design/svs_if.sv -----
// ----------------------------------------------------------------------------
// svs_if
// Valid/ready channels for raw classifications in and smoothed results out.
// ----------------------------------------------------------------------------
interface svs_in_if;
  logic                        valid;
  logic                        ready;
  logic [svs_pkg::CLASS_W-1:0] gesture_class;
  logic [svs_pkg::CONF_W-1:0]  confidence;

  modport source (output valid, gesture_class, confidence, input ready);
  modport sink   (input valid, gesture_class, confidence, output ready);
endinterface

interface svs_out_if;
  logic                        valid;
  logic                        ready;
  logic [svs_pkg::CLASS_W-1:0] smoothed_class;
  logic [svs_pkg::CONF_W-1:0]  smoothed_confidence;
  logic [svs_pkg::VOTE_W-1:0]  vote_count;
  logic                        has_result;

  modport source (output valid, smoothed_class, smoothed_confidence, vote_count,
                  has_result, input ready);
  modport sink   (input valid, smoothed_class, smoothed_confidence, vote_count,
                  has_result, output ready);
endinterface

// ----- design/sliding_window_vote_smoother.sv -----
// ----------------------------------------------------------------------------
// sliding_window_vote_smoother
// Majority vote over the most recent classifications, with the mean
// confidence of the winning class.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only in idle, once the previous
// result has gone to the output register. Each item is stored, the ring is
// read one entry per cycle, classes are scanned for the winner, the divider
// yields one quotient bit per cycle and the result waits for a free output.
// Reset (synchronous, rst_n low) empties the ring and restores the threshold
// to 32768 and the window to 5; ring contents are not cleared.
module sliding_window_vote_smoother (
  input  logic                           clk,
  input  logic                           rst_n,
  svs_in_if.sink                         in_ch,
  svs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [svs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import svs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  svs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  svs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_class  (in_ch.gesture_class),
    .in_conf   (in_ch.confidence),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_class (out_ch.smoothed_class),
    .out_conf  (out_ch.smoothed_confidence),
    .out_votes (out_ch.vote_count),
    .out_has   (out_ch.has_result)
  );

endmodule

// ----- design/svs_div.sv -----
// ----------------------------------------------------------------------------
// svs_div
// Restoring divider, one quotient bit per cycle: vote sum over vote count.
// ----------------------------------------------------------------------------
module svs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [svs_pkg::SUM_W-1:0] dividend,
  input  logic [svs_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [svs_pkg::SUM_W-1:0] quotient
);
  import svs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    if (start) begin
      busy_nxt  = 1'b1;
      count_nxt = DIV_CNT_W'(SUM_W);
      rem_nxt   = '0;
      quo_nxt   = dividend;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits the narrow register.
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      count_nxt = count_r - DIV_CNT_W'(1);
      if (count_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // The last quotient bit lands at the edge that ends this cycle.
  assign done     = busy_r && (count_r == DIV_CNT_W'(1));
  assign quotient = quo_r;

endmodule

// ----- design/svs_dp.sv -----
// ----------------------------------------------------------------------------
// svs_dp
// Datapath: configuration registers, entry ring, per-class tallies, winner
// search registers, mean divider and the output register.
// ----------------------------------------------------------------------------
module svs_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  svs_pkg::cmd_t                  cmd,
  output svs_pkg::stat_t                 stat,
  input  logic [svs_pkg::CLASS_W-1:0]    in_class,
  input  logic [svs_pkg::CONF_W-1:0]     in_conf,
  input  logic                           cfg_we,
  input  logic [svs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [svs_pkg::CLASS_W-1:0]    out_class,
  output logic [svs_pkg::CONF_W-1:0]     out_conf,
  output logic [svs_pkg::VOTE_W-1:0]     out_votes,
  output logic                           out_has
);
  import svs_pkg::*;

  logic [CONF_W-1:0] thr_r;
  logic [WIN_W-1:0]  win_r;

  entry_t            ring_mem [WINDOW_MAX];
  entry_t            rd_data_r;
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  rd_slot_r;
  logic [CNT_W-1:0]  occ_r;

  logic [CNT_W-1:0]  votes_r [NUM_CLASSES];
  logic [SUM_W-1:0]  sums_r  [NUM_CLASSES];
  logic [CLS_W-1:0]  best_idx_r;
  logic [CNT_W-1:0]  best_votes_r;
  logic [SUM_W-1:0]  best_sum_r;

  logic              out_valid_r;
  logic [CLASS_W-1:0] out_class_r;
  logic [CONF_W-1:0] out_conf_r;
  logic [VOTE_W-1:0] out_votes_r;
  logic              out_has_r;

  logic [CNT_W-1:0]  win_clamped;
  logic [CNT_W:0]    occ_inc;
  logic [CNT_W-1:0]  occ_nxt;
  logic [PTR_W-1:0]  wp_nxt;
  logic [PTR_W-1:0]  rd_slot_nxt;
  logic [CLS_W-1:0]  vidx;
  logic [CNT_W-1:0]  cur_votes;
  logic [SUM_W-1:0]  cur_sum;
  logic              qualifies;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      win_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata[CONF_W-1:0];
        REG_WINDOW:    win_r <= cfg_wdata[WIN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (win_r == '0) begin
      win_clamped = CNT_W'(1);
    end else if (int'(win_r) > WINDOW_MAX) begin
      win_clamped = CNT_W'(WINDOW_MAX);
    end else begin
      win_clamped = CNT_W'(win_r);
    end
  end

  // A shrunken window drops the oldest entries for good.
  assign occ_inc = {1'b0, occ_r} + (CNT_W+1)'(1);
  assign occ_nxt = (occ_inc > {1'b0, win_clamped}) ? win_clamped : occ_inc[CNT_W-1:0];

  assign wp_nxt      = (wp_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + PTR_W'(1);
  assign rd_slot_nxt = (rd_slot_r == '0) ? PTR_W'(WINDOW_MAX - 1)
                                         : rd_slot_r - PTR_W'(1);

  // Ring pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      occ_r <= '0;
    end else if (cmd.store) begin
      wp_r  <= wp_nxt;
      occ_r <= occ_nxt;
    end
  end

  // Entry ring: written on store, read back newest first.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring_mem[wp_r] <= '{cls: in_class, conf: in_conf};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_slot_r <= wp_r;
    end else if (cmd.rd) begin
      rd_slot_r <= rd_slot_nxt;
    end
    if (cmd.rd) begin
      rd_data_r <= ring_mem[rd_slot_r];
    end
  end

  // One tally port, shared by accumulation and the winner scan.
  assign vidx      = cmd.scan ? cmd.scan_idx : rd_data_r.cls[CLS_W-1:0];
  assign cur_votes = votes_r[vidx];
  assign cur_sum   = sums_r[vidx];
  assign qualifies = ({1'b0, rd_data_r.cls} < (CLASS_W+1)'(NUM_CLASSES)) &&
                     (rd_data_r.conf >= thr_r);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        votes_r[k] <= '0;
        sums_r[k]  <= '0;
      end
    end else if (cmd.acc && qualifies) begin
      votes_r[vidx] <= cur_votes + CNT_W'(1);
      sums_r[vidx]  <= cur_sum + SUM_W'(rd_data_r.conf);
    end
  end

  // Strictly greater keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      best_idx_r   <= '0;
      best_votes_r <= '0;
      best_sum_r   <= '0;
    end else if (cmd.scan && (cur_votes > best_votes_r)) begin
      best_idx_r   <= cmd.scan_idx;
      best_votes_r <= cur_votes;
      best_sum_r   <= cur_sum;
    end
  end

  svs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (best_sum_r),
    .divisor  (best_votes_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      if (best_votes_r == '0) begin
        out_class_r <= '0;
        out_conf_r  <= '0;
        out_votes_r <= '0;
        out_has_r   <= 1'b0;
      end else begin
        out_class_r <= CLASS_W'(best_idx_r);
        out_conf_r  <= CONF_W'(quotient);
        out_votes_r <= VOTE_W'(best_votes_r);
        out_has_r   <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_class = out_class_r;
  assign out_conf  = out_conf_r;
  assign out_votes = out_votes_r;
  assign out_has   = out_has_r;

  assign stat.occ      = occ_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  a_occ_after_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (occ_r != '0) && (int'(occ_r) <= WINDOW_MAX))
    else $error("occupancy out of range after a store");

  a_votes_within_occ: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (best_votes_r <= occ_r))
    else $error("winning vote count exceeds ring occupancy");

  a_has_matches_votes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_has_r == (out_votes_r != '0)))
    else $error("has_result disagrees with vote count");

endmodule

// ----- design/svs_ctrl.sv -----
// ----------------------------------------------------------------------------
// svs_ctrl
// Sequencer: store an item, walk the ring newest first, scan classes for the
// winner, run the divider and hand the result to the output register.
// ----------------------------------------------------------------------------
module svs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output svs_pkg::cmd_t  cmd,
  input  svs_pkg::stat_t stat
);
  import svs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ACCUM  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DSTART = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic             rd_pend_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cls_nxt       = cls_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.acc       = rd_pend_r;
    cmd.scan_idx  = cls_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        // Read data returns in the cycle after the read, so the last tally trails the reads.
        if (cnt_r < stat.occ) begin
          cmd.rd  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!rd_pend_r) begin
          cls_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (cls_r == CLS_W'(NUM_CLASSES - 1)) begin
          state_nxt = S_DSTART;
        end else begin
          cls_nxt = cls_r + CLS_W'(1);
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cls_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cls_r     <= cls_nxt;
      rd_pend_r <= cmd.rd;
    end
  end

  a_acc_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(cmd.rd))
    else $error("tally without a preceding ring read");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCUM) |-> (cnt_r <= stat.occ))
    else $error("ring walk ran past occupancy");

endmodule

// ----- tb/tb_sliding_window_vote_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_vote_smoother
// Self-checking bench for the vote smoother. Raw classifications are driven
// through the input channel under several threshold and window settings. A
// local copy of the ring and the vote predicts every smoothed result, and the
// results on the output channel are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_sliding_window_vote_smoother;
  import svs_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 150;

  // Indexes with no register behind them; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef enum {SRC_LIGHT_SINK_HEAVY, SRC_HEAVY_SINK_LIGHT, NO_GAPS} gap_mode_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CONF_W-1:0]  conf;
  } raw_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CONF_W-1:0]  conf;
    logic [VOTE_W-1:0]  votes;
    logic               has;
  } smoothed_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  svs_in_if  in_ch ();
  svs_out_if out_ch ();

  sliding_window_vote_smoother u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  raw_item_t pending_items[$];
  smoothed_t expected_results[$];

  // Predictor state: history ring, slot pointer, kept entries and registers.
  logic [CLASS_W-1:0] cls_hist [WINDOW_MAX];
  logic [CONF_W-1:0]  conf_hist [WINDOW_MAX];
  int unsigned        next_slot;
  int unsigned        kept_count;
  logic [CONF_W-1:0]  vote_threshold;
  logic [WIN_W-1:0]   window_setting;

  gap_mode_t gap_mode;
  bit        hold_armed;
  bit        hold_taken;
  int        hold_left;
  logic      in_fire;
  int        stall_cycles;
  int        mismatch_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stores one item in the history and votes over the kept entries.
  function automatic smoothed_t store_and_vote(input logic [CLASS_W-1:0] cls,
                                               input logic [CONF_W-1:0] conf);
    int unsigned span;
    int unsigned slot;
    int unsigned best;
    int unsigned best_votes;
    int unsigned tally [NUM_CLASSES];
    int unsigned conf_total [NUM_CLASSES];
    smoothed_t   res;
    span = (window_setting == 0) ? 1 :
           (window_setting > WINDOW_MAX) ? WINDOW_MAX : window_setting;
    cls_hist[next_slot]  = cls;
    conf_hist[next_slot] = conf;
    next_slot = (next_slot + 1 >= WINDOW_MAX) ? 0 : next_slot + 1;
    kept_count = (kept_count + 1 > span) ? span : kept_count + 1;
    foreach (tally[c]) begin
      tally[c] = 0;
      conf_total[c] = 0;
    end
    slot = next_slot;
    for (int i = 0; i < kept_count; i++) begin
      slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
      if (cls_hist[slot] < NUM_CLASSES && conf_hist[slot] >= vote_threshold) begin
        tally[cls_hist[slot]]++;
        conf_total[cls_hist[slot]] += conf_hist[slot];
      end
    end
    best = 0;
    best_votes = 0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (tally[c] > best_votes) begin
        best_votes = tally[c];
        best = c;
      end
    end
    res = '0;
    if (best_votes != 0) begin
      res.cls   = CLASS_W'(best);
      res.conf  = CONF_W'(conf_total[best] / best_votes);
      res.votes = VOTE_W'(best_votes);
      res.has   = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [CONF_W-1:0] random_confidence();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return vote_threshold;
      3: return vote_threshold - 1'b1;
      4: return vote_threshold + 1'b1;
      default: return CONF_W'($urandom);
    endcase
  endfunction

  // Mostly the dominant class, some other valid classes, some "none" codes.
  function automatic logic [CLASS_W-1:0] random_class(input int unsigned dominant);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return CLASS_W'(dominant);
    if (pick < 85) return CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
    return CLASS_W'($urandom_range(NUM_CLASSES, 15));
  endfunction

  task automatic queue_item(input logic [CLASS_W-1:0] cls, input logic [CONF_W-1:0] conf);
    raw_item_t item;
    item.cls  = cls;
    item.conf = conf;
    pending_items = {pending_items, item};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_THRESHOLD) vote_threshold = data[CONF_W-1:0];
    else if (idx == REG_WINDOW) window_setting = data[WIN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every item yields a result, so the block is idle once none is owed.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] win,
                           input gap_mode_t mode);
    int made;
    int unsigned dominant;
    int unsigned run_len;
    wait_idle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WINDOW, win);
    gap_mode = mode;
    made = 0;
    // Runs of one dominant class so that majorities actually form.
    while (made < PHASE_ITEMS) begin
      dominant = $urandom_range(0, NUM_CLASSES - 1);
      run_len = $urandom_range(3, 12);
      for (int k = 0; k < run_len && made < PHASE_ITEMS; k++) begin
        queue_item(random_class(dominant), random_confidence());
        made++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.gesture_class = '0;
    in_ch.confidence = '0;
    out_ch.ready = 1'b0;
    gap_mode = SRC_LIGHT_SINK_HEAVY;
    hold_armed = 1'b0;
    mismatch_count = 0;
    vote_threshold = THRESHOLD_RESET;
    window_setting = WINDOW_RESET;
    next_slot = 0;
    kept_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, the threshold edge, none codes and a tie.
    queue_item(4'd0, 16'hFFFF);
    queue_item(4'd7, 16'd32768);
    queue_item(4'd7, 16'd32767);
    queue_item(4'd8, 16'hFFFF);
    queue_item(4'd15, 16'hFFFF);
    queue_item(4'd7, 16'd40000);
    wait_idle();
    // Zero threshold lets everything vote; a zero window acts as one.
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_WINDOW, 16'd0);
    queue_item(4'd0, 16'd0);
    queue_item(4'd15, 16'd0);
    queue_item(4'd3, 16'd1);
    wait_idle();
    // Window above the maximum is clamped; spare indexes must do nothing.
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_WINDOW, 16'd63);
    write_reg(REG_SPARE_A, 16'd1);
    write_reg(REG_SPARE_B, 16'd0);
    queue_item(4'd2, 16'hFFFF);
    queue_item(4'd2, 16'hFFFE);
    queue_item(4'd5, 16'hFFFF);
    queue_item(4'd5, 16'hFFFF);
    queue_item(4'd1, 16'hFFFF);
    wait_idle();
    // Shrinking the window drops the oldest entries.
    write_reg(REG_THRESHOLD, 16'd32768);
    write_reg(REG_WINDOW, 16'd2);
    queue_item(4'd4, 16'd50000);
    queue_item(4'd4, 16'd50001);
    queue_item(4'd6, 16'd65000);

    run_phase(CONF_W'($urandom), 16'd8, SRC_LIGHT_SINK_HEAVY);
    run_phase(16'd0, 16'd32, SRC_LIGHT_SINK_HEAVY);
    run_phase(16'hFFFF, 16'h003F, SRC_HEAVY_SINK_LIGHT);
    // Only the low six bits reach the window register, giving zero here.
    run_phase(16'd32768, 16'hFFC0, SRC_HEAVY_SINK_LIGHT);
    run_phase(CONF_W'($urandom), 16'd3, NO_GAPS);
    hold_armed = 1'b1;
    wait_idle();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    run_phase(16'd1000, 16'd40, NO_GAPS);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Sender: offers the next pending item once the current one is taken.
  always @(negedge clk) begin
    raw_item_t item;
    bit gap;
    gap = (gap_mode == SRC_LIGHT_SINK_HEAVY) ? ($urandom_range(0, 99) < 17) :
          (gap_mode == SRC_HEAVY_SINK_LIGHT) ? ($urandom_range(0, 99) < 76) : 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && !gap) begin
        item = pending_items[0];
        pending_items.delete(0);
        in_ch.valid <= 1'b1;
        in_ch.gesture_class <= item.cls;
        in_ch.confidence <= item.conf;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  always @(negedge clk) begin
    bit gap;
    gap = (gap_mode == SRC_LIGHT_SINK_HEAVY) ? ($urandom_range(0, 99) < 76) :
          (gap_mode == SRC_HEAVY_SINK_LIGHT) ? ($urandom_range(0, 99) < 17) : 1'b0;
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !gap;
    end
  end

  task automatic report_mismatch(input string what, input smoothed_t want,
                                 input smoothed_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected class %0d conf %0d votes %0d has %0d",
               $realtime, what, want.cls, want.conf, want.votes, want.has);
      $display("    got class %0d conf %0d votes %0d has %0d",
               got.cls, got.conf, got.votes, got.has);
    end
  endtask

  // Monitor: checks results against the oldest prediction, then predicts
  // the result of any item accepted at this edge.
  always @(posedge clk) begin
    smoothed_t got;
    smoothed_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got.cls   = out_ch.smoothed_class;
        got.conf  = out_ch.smoothed_confidence;
        got.votes = out_ch.vote_count;
        got.has   = out_ch.has_result;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.cls !== want.cls || got.conf !== want.conf ||
              got.votes !== want.votes || got.has !== want.has) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = store_and_vote(in_ch.gesture_class, in_ch.confidence);
        expected_results = {expected_results, want};
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
